// ===== hw/rtl/dequ_pkg.sv =====
// Shared types and constants for the double-ended queue unit.
// Used by every module of the block; depends on nothing.
package dequ_pkg;

    localparam int CAPACITY     = 16;
    localparam int RECORD_WIDTH = 32;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    // Cell next-value selection codes
    localparam logic [1:0] SEL_HOLD  = 2'd0;
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;
    localparam logic [1:0] SEL_ITEM  = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] item_data;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [4:0]  entry_count;
        logic        front_valid;
        logic [31:0] front_data;
        logic        back_valid;
        logic [31:0] back_data;
    } t_out;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic [1:0] sel;   // next-value source
        logic       last;  // cell holds the back entry
    } t_cell_ctl;

endpackage

// ===== hw/rtl/dequ_cell.sv =====
// One storage cell of the deque chain: holds one record word.
// Takes its next value from its left or right neighbor, the input word, or itself.
// Depends on dequ_pkg.
module dequ_cell
    import dequ_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic [RECORD_WIDTH-1:0] i_left,
    input  logic [RECORD_WIDTH-1:0] i_right,
    input  logic [RECORD_WIDTH-1:0] i_item,
    output logic [RECORD_WIDTH-1:0] o_data,
    output logic [RECORD_WIDTH-1:0] o_back
);

    logic [RECORD_WIDTH-1:0] r_data;
    logic [RECORD_WIDTH-1:0] n_data;

    // Pick the next word
    always_comb begin
        case (i_ctl.sel)
            SEL_LEFT:  n_data = i_left;
            SEL_RIGHT: n_data = i_right;
            SEL_ITEM:  n_data = i_item;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Offer the word to the back-entry OR tree only when this cell is last
    assign o_back = i_ctl.last ? r_data : '0;

endmodule

// ===== hw/rtl/dequ_ctrl.sv =====
// Sequencer of the deque: handshake, entry count, result flag and cell controls.
// Decodes each transferred operation into shift or load commands for the cell chain.
// Depends on dequ_pkg.
module dequ_ctrl
    import dequ_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_operation,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_ok,
    output logic [CNT_W-1:0] o_count,
    output t_cell_ctl        o_cell_ctl [CAPACITY]
);

    logic             r_out_valid;
    logic             r_ok;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             ok;
    logic             accept;
    logic             full;
    logic             empty;
    logic             do_shift_right;
    logic             do_shift_left;
    logic             do_load_back;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);

    // Decode the operation
    always_comb begin
        ok             = 1'b0;
        n_count        = r_count;
        do_shift_right = 1'b0;
        do_shift_left  = 1'b0;
        do_load_back   = 1'b0;
        unique case (i_operation)
            OP_PUSH_FRONT: begin
                ok             = !full;
                do_shift_right = !full;
                if (!full) n_count = r_count + CNT_W'(1);
            end
            OP_PUSH_BACK: begin
                ok           = !full;
                do_load_back = !full;
                if (!full) n_count = r_count + CNT_W'(1);
            end
            OP_POP_FRONT: begin
                ok            = !empty;
                do_shift_left = !empty;
                if (!empty) n_count = r_count - CNT_W'(1);
            end
            OP_POP_BACK: begin
                ok = !empty;
                if (!empty) n_count = r_count - CNT_W'(1);
            end
            OP_QUERY: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Drive each cell of the chain
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            o_cell_ctl[i].sel  = SEL_HOLD;
            o_cell_ctl[i].last = (r_count == CNT_W'(i + 1));
            if (accept) begin
                if (do_shift_right) begin
                    o_cell_ctl[i].sel = SEL_LEFT;
                end else if (do_shift_left) begin
                    o_cell_ctl[i].sel = SEL_RIGHT;
                end else if (do_load_back && (r_count == CNT_W'(i))) begin
                    o_cell_ctl[i].sel = SEL_ITEM;
                end
            end
        end
    end

    // Advance count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
            r_count     <= '0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
            r_ok        <= ok;
            r_count     <= n_count;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_count     = r_count;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Bounded double-ended queue of 16 record words built as a chain of storage cells.
// Top level; instantiates dequ_ctrl and dequ_cell, uses dequ_pkg.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one operation per transfer:
// push front, push back, pop front, pop back or query. Output channel
// (o_out_valid / i_out_ready / o_out_data): exactly one result per operation,
// with the success flag, the entry count after the operation and the words at the
// front and back, each with a valid flag (data reads zero when the deque is empty).
//
// The front entry always sits in the first cell and the back entry in the cell at
// position count-1. A push front shifts the whole chain one cell toward the back,
// a pop front shifts it one cell toward the front, and a push back loads the cell
// just past the back; each is one step of the chain, a shift moving every cell at once.
// The result is registered and appears the cycle after the input transfer. One
// operation per cycle while the receiver takes results; a new operation is taken
// in the same cycle the held result is transferred.
// Reset empties the deque (count zero, no result pending); cell contents are not
// cleared. When the receiver stalls the result is held and o_in_ready drops.
module double_ended_queue_unit
    import dequ_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cell_ctl               cell_ctl  [CAPACITY];
    logic [RECORD_WIDTH-1:0] cell_data [CAPACITY];
    logic [RECORD_WIDTH-1:0] cell_back [CAPACITY];
    logic [RECORD_WIDTH-1:0] item;
    logic [RECORD_WIDTH-1:0] back_word;
    logic [CNT_W-1:0]        count;
    logic                    ok;
    logic                    not_empty;

    assign item = i_in_data.item_data[RECORD_WIDTH-1:0];

    dequ_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_data.operation),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ok        (ok),
        .o_count     (count),
        .o_cell_ctl  (cell_ctl)
    );

    // Chain of cells; the first takes the pushed word from the left
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dequ_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_left  ((g == 0) ? item : cell_data[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? cell_data[g]
                                          : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_item  (item),
            .o_data  (cell_data[g]),
            .o_back  (cell_back[g])
        );
    end

    // Collect the back entry: only the last occupied cell drives nonzero
    always_comb begin
        back_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            back_word = back_word | cell_back[i];
        end
    end

    assign not_empty = (count != '0);

    // Build the result from the state left by the operation
    always_comb begin
        o_out_data             = '0;
        o_out_data.ok          = ok;
        o_out_data.entry_count = 5'(count);
        o_out_data.front_valid = not_empty;
        o_out_data.back_valid  = not_empty;
        if (not_empty) begin
            o_out_data.front_data = 32'(cell_data[0]);
            o_out_data.back_data  = 32'(back_word);
        end
    end

endmodule

// ===== hw/rtl/dequ_checker.sv =====
// Port-level checks for the double-ended queue unit, bound to the top level.
// Depends on dequ_pkg.
module dequ_checker
    import dequ_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // Take input whenever no result is pending
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with no result pending");

    // Keep front and back flags consistent with the count
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.entry_count <= 5'(CAPACITY))
            && (o_out_data.front_valid == (o_out_data.entry_count != 5'd0))
            && (o_out_data.back_valid == o_out_data.front_valid))
        else $error("count or valid flags inconsistent");

    // A query always succeeds on the next cycle
    a_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.operation == OP_QUERY)
        |=> o_out_valid && o_out_data.ok)
        else $error("query result missing or failed");

    // A successful push front shows the pushed word at the front
    a_push_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.operation == OP_PUSH_FRONT)
        |=> !o_out_data.ok || (o_out_data.front_data == $past(i_in_data.item_data)))
        else $error("front word differs from pushed word");

endmodule

bind double_ended_queue_unit dequ_checker u_dequ_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
